### rtl/kfl_pkg.sv
// ----------------------------------------------------------------------------
// kfl_pkg: shared types and constants
// Widths, status codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package kfl_pkg;

  localparam int MaxKeys  = 64;
  localparam int SlotW    = $clog2(MaxKeys);
  localparam int CountW   = 7;
  localparam int DataW    = 32;
  localparam int FracW    = 16;
  // Quotient magnitude: up to 33 + 16 bits.
  localparam int QuotW    = 49;
  localparam int DivW     = 33;
  localparam int DivCntW  = $clog2(QuotW + 1);
  localparam int CfgIdxW  = 8;

  localparam logic [DataW-1:0] QOne = 32'h0001_0000;

  localparam logic [1:0] StatInterp = 2'd0;
  localparam logic [1:0] StatEmpty  = 2'd1;
  localparam logic [1:0] StatSingle = 2'd2;
  localparam logic [1:0] StatZero   = 2'd3;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgKeyCount = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgEmptyOne = 8'd1;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [DataW-1:0] t;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] z;
  } key_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic             rd_en;     // read table entry rd_addr
    logic [SlotW-1:0] rd_addr;
    logic             cap_a;     // capture read data as segment start
    logic             cap_b;     // capture read data as segment end
    logic             div_start; // load operands into divider
    logic             div_step;  // one restoring division step
    logic [1:0]       comp_sel;  // component for multiply stage
    logic             mul_step;  // multiply selected component
    logic             fin_step;  // finish selected component
    logic             load_out;  // load output register
    logic [1:0]       out_status;
    logic             use_default;
    logic             use_a;
  } dp_cmd_t;

  typedef struct packed {
    logic             t_less;    // query time < time read
    logic             d_zero;    // segment interval is zero
  } dp_stat_t;

endpackage

### rtl/kfl_if.sv
// ----------------------------------------------------------------------------
// kfl_if: valid/ready channel
// Generic payload channel with source and sink modports.
// ----------------------------------------------------------------------------
interface kfl_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/keyframe_vec3_lerp_unit.sv
// ----------------------------------------------------------------------------
// keyframe_vec3_lerp_unit: keyframe track interpolator
// Loads keys into a track table and answers time queries with a linearly
// interpolated Q16.16 vector.
// ----------------------------------------------------------------------------
// Usage: the input channel carries load and query items. A load transfer
// writes one key into the table and produces no result. A query transfer
// produces exactly one result transfer on the output channel. A query
// scans the track one key at a time (read, then compare), then runs a
// 49-step restoring divider for the interpolation factor and three
// multiply/finish passes on a shared multiplier. A zero-interval segment
// skips the divider and the passes, and a search that finds no later key
// time above the query time ends in the last segment. Empty and
// single-key tracks skip the search and the arithmetic. One item is in
// work at a time; the input is ready again in the cycle after the
// result transfer, once the result register is free again.
// Configuration writes (index 0 key_count, index 1 empty_default_one) are
// taken in any cycle and are meant to happen while the block is idle.
// Reset clears the controller, out_valid and config registers; the key
// table keeps its contents and must be loaded before it is queried.
// When the receiver stalls, the result holds in the output register.
// ----------------------------------------------------------------------------
module keyframe_vec3_lerp_unit (
  input logic clk,
  input logic rst,
  kfl_if.sink   in_ch,
  kfl_if.sink   cfg,
  kfl_if.source out_ch
);
  import kfl_pkg::*;

  logic [CountW-1:0] key_count;
  logic              empty_one;

  // The configuration port is always ready.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      empty_one <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.data.index == CfgKeyCount) begin
        key_count <= cfg.data.value[CountW-1:0];
      end else if (cfg.data.index == CfgEmptyOne) begin
        empty_one <= cfg.data.value[0];
      end
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     query_cap;
  logic     key_we;
  key_t     key_wr;

  // A load writes its key in the transfer cycle itself.
  assign key_we = in_ch.valid && in_ch.ready && (in_ch.data.cmd == CmdLoad);
  assign key_wr = '{slot: in_ch.data.key_slot, t: in_ch.data.key_time,
                    x: in_ch.data.key_x, y: in_ch.data.key_y, z: in_ch.data.key_z};

  kfl_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_cmd(in_ch.data.cmd), .in_ready(in_ch.ready),
    .query_cap, .key_count, .cmd, .stat,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );

  kfl_datapath u_dp (
    .clk, .key_we, .key_wr, .query_time(in_ch.data.query_time), .query_cap,
    .empty_one, .cmd, .stat,
    .res_x(out_ch.data.out_x), .res_y(out_ch.data.out_y),
    .res_z(out_ch.data.out_z), .res_status(out_ch.data.status)
  );
endmodule

### rtl/kfl_ram.sv
// ----------------------------------------------------------------------------
// kfl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kfl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/kfl_datapath.sv
// ----------------------------------------------------------------------------
// kfl_datapath: key tables and interpolation arithmetic
// Holds the key memories, a serial divider for the factor and a shared
// multiplier that forms one component term per step.
// ----------------------------------------------------------------------------
module kfl_datapath (
  input  logic                          clk,
  input  logic                          key_we,
  input  kfl_pkg::key_t                 key_wr,
  input  logic [kfl_pkg::DataW-1:0]     query_time,
  input  logic                          query_cap,
  input  logic                          empty_one,
  input  kfl_pkg::dp_cmd_t              cmd,
  output kfl_pkg::dp_stat_t             stat,
  output logic [kfl_pkg::DataW-1:0]     res_x,
  output logic [kfl_pkg::DataW-1:0]     res_y,
  output logic [kfl_pkg::DataW-1:0]     res_z,
  output logic [1:0]                    res_status
);
  import kfl_pkg::*;

  logic [DataW-1:0] rd_t, rd_x, rd_y, rd_z;

  kfl_ram #(.Width(DataW), .Depth(MaxKeys)) u_t (.clk, .we(key_we), .waddr(key_wr.slot),
    .wdata(key_wr.t), .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rd_t));
  kfl_ram #(.Width(DataW), .Depth(MaxKeys)) u_x (.clk, .we(key_we), .waddr(key_wr.slot),
    .wdata(key_wr.x), .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rd_x));
  kfl_ram #(.Width(DataW), .Depth(MaxKeys)) u_y (.clk, .we(key_we), .waddr(key_wr.slot),
    .wdata(key_wr.y), .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rd_y));
  kfl_ram #(.Width(DataW), .Depth(MaxKeys)) u_z (.clk, .we(key_we), .waddr(key_wr.slot),
    .wdata(key_wr.z), .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rd_z));

  logic [DataW-1:0] qt;
  logic [DataW-1:0] t0, ax, ay, az, bx, by, bz;
  logic [DataW-1:0] t1;

  always_ff @(posedge clk) begin
    if (query_cap) begin
      qt <= query_time;
    end
    if (cmd.cap_a) begin
      t0 <= rd_t; ax <= rd_x; ay <= rd_y; az <= rd_z;
    end
    if (cmd.cap_b) begin
      t1 <= rd_t; bx <= rd_x; by <= rd_y; bz <= rd_z;
    end
  end

  assign stat.t_less = qt < rd_t;
  assign stat.d_zero = (t1 == t0);

  // Restoring divider: (|num| << 16) / |d|, one quotient bit per step.
  logic [DivW:0]    d_full, n_full;
  logic [DivW-1:0]  dm, nm;
  logic [DivW-1:0]  dm_r;
  logic             fneg;
  logic [QuotW-1:0] dividend;
  logic [DivW:0]    rem;
  logic [DivW:0]    rem_sh;
  logic [DivW:0]    rem_sub;

  assign d_full = {2'b00, t1} - {2'b00, t0};
  assign n_full = {2'b00, qt} - {2'b00, t0};
  assign dm     = d_full[DivW] ? DivW'(-d_full) : d_full[DivW-1:0];
  assign nm     = n_full[DivW] ? DivW'(-n_full) : n_full[DivW-1:0];
  assign rem_sh  = {rem[DivW-1:0], dividend[QuotW-1]};
  assign rem_sub = rem_sh - {1'b0, dm_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend <= {nm, {FracW{1'b0}}};
      rem      <= '0;
      dm_r     <= dm;
      fneg     <= n_full[DivW] ^ d_full[DivW];
    end else if (cmd.div_step) begin
      if (!rem_sub[DivW]) begin
        rem      <= rem_sub;
        dividend <= {dividend[QuotW-2:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        dividend <= {dividend[QuotW-2:0], 1'b0};
      end
    end
  end

  // After QuotW steps, dividend holds the quotient fmag.
  logic [QuotW-FracW-1:0] fhi;
  logic [FracW-1:0]       flo;
  assign fhi = dividend[QuotW-1:FracW];
  assign flo = dividend[FracW-1:0];

  logic [DataW-1:0] sel_a, sel_b;
  always_comb begin
    case (cmd.comp_sel)
      2'd0:    begin sel_a = ax; sel_b = bx; end
      2'd1:    begin sel_a = ay; sel_b = by; end
      default: begin sel_a = az; sel_b = bz; end
    endcase
  end

  logic [DivW:0]   diff;
  logic [DivW-1:0] m;
  assign diff = {{2{sel_b[DataW-1]}}, sel_b} - {{2{sel_a[DataW-1]}}, sel_a};
  assign m    = diff[DivW] ? DivW'(-diff) : diff[DivW-1:0];

  // Multiply stage: registers m*lo and m*hi with the sign and a zero flag.
  // hi is at most 33 bits; product bound check: term needs m*hi < 2^41.
  logic [DivW+FracW-1:0]       p_lo;
  logic [2*DivW-1:0]           p_hi;
  logic                        neg_r, mzero_r;
  logic [DataW-1:0]            a_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      p_lo    <= m * flo;
      p_hi    <= m * fhi;
      neg_r   <= diff[DivW] ^ fneg;
      mzero_r <= (m == '0);
      a_r     <= sel_a;
    end
  end

  // Finish stage: combine, apply sign, saturate.
  logic              big;
  logic [42:0]       term;
  logic signed [44:0] r;
  logic [DataW-1:0]  fin;

  always_comb begin
    big  = |p_hi[2*DivW-1:41];
    term = {2'b00, p_hi[40:0]} + 43'(p_lo >> FracW);
    r    = neg_r ? 45'($signed(a_r)) - $signed({2'b00, term})
                 : 45'($signed(a_r)) + $signed({2'b00, term});
    if (mzero_r) begin
      fin = a_r;
    end else if (big || term[42] || term[41]) begin
      fin = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (r > 45'sd2147483647) begin
      fin = 32'h7FFF_FFFF;
    end else if (r < -45'sd2147483648) begin
      fin = 32'h8000_0000;
    end else begin
      fin = r[DataW-1:0];
    end
  end

  logic [DataW-1:0] cx, cy, cz;
  always_ff @(posedge clk) begin
    if (cmd.fin_step) begin
      case (cmd.comp_sel)
        2'd0:    cx <= fin;
        2'd1:    cy <= fin;
        default: cz <= fin;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_status <= cmd.out_status;
      if (cmd.use_default) begin
        res_x <= empty_one ? QOne : '0;
        res_y <= empty_one ? QOne : '0;
        res_z <= empty_one ? QOne : '0;
      end else if (cmd.use_a) begin
        res_x <= ax; res_y <= ay; res_z <= az;
      end else begin
        res_x <= cx; res_y <= cy; res_z <= cz;
      end
    end
  end
endmodule

### rtl/kfl_ctrl.sv
// ----------------------------------------------------------------------------
// kfl_ctrl: sequencer for loads and queries
// Runs the linear search, the divider and the per-component steps.
// ----------------------------------------------------------------------------
module kfl_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_cmd,
  output logic                       in_ready,
  output logic                       query_cap,
  input  logic [kfl_pkg::CountW-1:0] key_count,
  output kfl_pkg::dp_cmd_t           cmd,
  input  kfl_pkg::dp_stat_t          stat,
  output logic                       out_valid,
  input  logic                       out_ready
);
  import kfl_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SSearch = 4'd1;
  localparam logic [3:0] SCheck  = 4'd2;
  localparam logic [3:0] SRdA    = 4'd3;
  localparam logic [3:0] SCapA   = 4'd4;
  localparam logic [3:0] SCapB   = 4'd5;
  localparam logic [3:0] SDecide = 4'd6;
  localparam logic [3:0] SDiv    = 4'd7;
  localparam logic [3:0] SMul    = 4'd8;
  localparam logic [3:0] SFin    = 4'd9;
  localparam logic [3:0] SLoad   = 4'd10;

  logic [3:0]         state, state_next;
  logic [SlotW:0]     idx, idx_next;       // candidate segment index
  logic [SlotW:0]     n_keys;
  logic [DivCntW-1:0] cnt, cnt_next;
  logic [1:0]         comp, comp_next;
  logic [1:0]         st, st_next;
  logic               dflt, dflt_next, usea, usea_next;
  logic               ovalid_next;

  assign n_keys = (key_count > CountW'(MaxKeys)) ? (SlotW+1)'(MaxKeys)
                                                 : key_count[SlotW:0];
  assign in_ready = (state == SIdle) && !out_valid;
  assign query_cap = in_valid && in_ready && (in_cmd == CmdQuery);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle; out_valid <= 1'b0;
    end else begin
      state <= state_next; out_valid <= ovalid_next;
    end
    idx <= idx_next; cnt <= cnt_next; comp <= comp_next;
    st <= st_next; dflt <= dflt_next; usea <= usea_next;
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    cnt_next    = cnt;
    comp_next   = comp;
    st_next     = st;
    dflt_next   = dflt;
    usea_next   = usea;
    ovalid_next = out_valid && !out_ready;
    cmd         = '0;
    cmd.comp_sel = comp;
    cmd.out_status = st;
    cmd.use_default = dflt;
    cmd.use_a = usea;
    unique case (state)
      SIdle: begin
        if (query_cap) begin
          idx_next = '0;
          if (n_keys == '0) begin
            st_next = StatEmpty; dflt_next = 1'b1; usea_next = 1'b0;
            state_next = SLoad;
          end else if (n_keys == (SlotW+1)'(1)) begin
            st_next = StatSingle; dflt_next = 1'b0; usea_next = 1'b1;
            state_next = SRdA;
          end else begin
            state_next = SSearch;
          end
        end
      end
      SSearch: begin
        // Read time of key idx+1, unless idx is already the last segment.
        if (idx + (SlotW+1)'(2) >= n_keys) begin
          state_next = SRdA;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = SlotW'(idx + (SlotW+1)'(1));
          state_next = SCheck;
        end
      end
      SCheck: begin
        if (stat.t_less) begin
          state_next = SRdA;
        end else begin
          idx_next = idx + (SlotW+1)'(1);
          state_next = SSearch;
        end
      end
      SRdA: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = idx[SlotW-1:0];
        state_next = SCapA;
      end
      SCapA: begin
        cmd.cap_a = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_addr = SlotW'(idx + (SlotW+1)'(1));
        state_next = (st == StatSingle && usea) ? SLoad : SCapB;
      end
      SCapB: begin
        cmd.cap_b = 1'b1;
        state_next = SDecide;
      end
      SDecide: begin
        if (stat.d_zero) begin
          st_next = StatZero; usea_next = 1'b1; dflt_next = 1'b0;
          state_next = SLoad;
        end else begin
          st_next = StatInterp; usea_next = 1'b0; dflt_next = 1'b0;
          cmd.div_start = 1'b1;
          cnt_next = '0;
          state_next = SDiv;
        end
      end
      SDiv: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + DivCntW'(1);
        if (cnt == DivCntW'(QuotW - 1)) begin
          comp_next = 2'd0;
          state_next = SMul;
        end
      end
      SMul: begin
        cmd.mul_step = 1'b1;
        state_next = SFin;
      end
      SFin: begin
        cmd.fin_step = 1'b1;
        if (comp == 2'd2) begin
          state_next = SLoad;
        end else begin
          comp_next = comp + 2'd1;
          state_next = SMul;
        end
      end
      SLoad: begin
        cmd.load_out = 1'b1;
        ovalid_next = 1'b1;
        st_next = st;
        state_next = SIdle;
      end
      default: state_next = SIdle;
    endcase
    // Single-key path ends after capturing key 0; multi-key queries clear the marker.
    if (state == SIdle && query_cap && n_keys > (SlotW+1)'(1)) begin
      st_next = StatInterp; usea_next = 1'b0; dflt_next = 1'b0;
    end
  end
endmodule

### rtl/kfl_checker.sv
// ----------------------------------------------------------------------------
// kfl_checker: port-level assertions
// Checks result ordering and handshake behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
module kfl_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_cmd,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status
);
  // A result never appears in the cycle right after a query transfer.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd |=> !out_valid) else $error("early result");
  // No new item is taken while a result waits.
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
  // A stalled result keeps its status.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");
  // A load produces no result right after it.
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_cmd && !out_valid |=> !out_valid)
    else $error("load produced a result");
endmodule

bind keyframe_vec3_lerp_unit kfl_checker u_kfl_checker (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data.cmd),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data.status)
);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for keyframe_vec3_lerp_unit
// Loads key tracks, sets key_count and the empty-track default between
// phases, and checks every query result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb;
  import kfl_pkg::*;

  // Input transfer: a key load or a time query.
  typedef struct packed {
    logic             cmd;
    logic [SlotW-1:0] key_slot;
    logic [DataW-1:0] key_time;
    logic [DataW-1:0] key_x;
    logic [DataW-1:0] key_y;
    logic [DataW-1:0] key_z;
    logic [DataW-1:0] query_time;
  } req_t;

  // Configuration write: register index and value.
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CountW-1:0]  value;
  } cfg_t;

  // One interpolated vector with its status.
  typedef struct packed {
    logic [DataW-1:0] out_x;
    logic [DataW-1:0] out_y;
    logic [DataW-1:0] out_z;
    logic [1:0]       status;
  } vec_t;

  localparam int TargetItems = 1550;
  localparam int SettleCycles = 300;
  localparam int LongHold = 400;

  logic clk;
  logic rst;

  kfl_if #(.payload_t(req_t)) in_ch ();
  kfl_if #(.payload_t(cfg_t)) cfg ();
  kfl_if #(.payload_t(vec_t)) out_ch ();

  keyframe_vec3_lerp_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .out_ch (out_ch)
  );

  // Predictor copy of the track table and configuration.
  bit [31:0] time_tab [MaxKeys];
  bit [31:0] x_tab [MaxKeys];
  bit [31:0] y_tab [MaxKeys];
  bit [31:0] z_tab [MaxKeys];
  bit [6:0]  track_len;
  bit        unit_default;

  req_t pending_reqs [$];
  vec_t expected_vecs [$];
  int   mismatches;
  int   accepted_items;
  int   items_queued;
  bit   calm;        // no idling in the last part of the run

  // Clock, and every input held at a known value from time zero.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    out_ch.ready = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One component: a + f*(b - a) with f in sign/magnitude Q.16, saturated.
  function automatic bit [31:0] lerp_component(bit [31:0] a_bits, bit [31:0] b_bits,
                                               bit fneg, bit [63:0] fmag);
    longint    a;
    longint    diff;
    longint    r;
    longint    term;
    bit        neg;
    bit [63:0] m;
    bit [63:0] hi;
    bit [63:0] lo;
    a = longint'(signed'(a_bits));
    diff = longint'(signed'(b_bits)) - a;
    neg = (diff < 0) != fneg;
    m = (diff < 0) ? -diff : diff;
    hi = fmag >> 16;
    lo = fmag & 64'hFFFF;
    if (m == 0) begin
      r = a;
    end else if (hi != 0 && hi > ((64'd1 << 40) / m)) begin
      r = neg ? -longint'(64'h8000_0000) : longint'(64'h7FFF_FFFF);
    end else begin
      term = longint'(m * hi + ((m * lo) >> 16));
      r = neg ? a - term : a + term;
    end
    if (r > longint'(64'h7FFF_FFFF)) r = longint'(64'h7FFF_FFFF);
    if (r < -longint'(64'h8000_0000)) r = -longint'(64'h8000_0000);
    return r[31:0];
  endfunction

  // Evaluates the track at one query time.
  function automatic vec_t evaluate_track(bit [31:0] qt);
    vec_t      v;
    int        n;
    int        i;
    longint    d;
    longint    num;
    bit [63:0] nm;
    bit [63:0] dm;
    bit [63:0] fmag;
    bit        fneg;
    n = (track_len > MaxKeys) ? MaxKeys : track_len;
    if (n == 0) begin
      v.out_x = unit_default ? QOne : '0;
      v.out_y = v.out_x;
      v.out_z = v.out_x;
      v.status = StatEmpty;
      return v;
    end
    if (n == 1) begin
      v = '{x_tab[0], y_tab[0], z_tab[0], StatSingle};
      return v;
    end
    // The last segment catches everything past the end of the track.
    i = 0;
    while (i + 2 < n && !(qt < time_tab[i+1])) i++;
    d = longint'(time_tab[i+1]) - longint'(time_tab[i]);
    if (d == 0) begin
      v = '{x_tab[i], y_tab[i], z_tab[i], StatZero};
      return v;
    end
    num = longint'(qt) - longint'(time_tab[i]);
    nm = (num < 0) ? -num : num;
    dm = (d < 0) ? -d : d;
    fmag = (nm << 16) / dm;
    fneg = (num < 0) != (d < 0);
    v.out_x = lerp_component(x_tab[i], x_tab[i+1], fneg, fmag);
    v.out_y = lerp_component(y_tab[i], y_tab[i+1], fneg, fmag);
    v.out_z = lerp_component(z_tab[i], z_tab[i+1], fneg, fmag);
    v.status = StatInterp;
    return v;
  endfunction

  task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: feeds pending items, with random gaps between transfers.
  // --------------------------------------------------------------------------
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() > 0) begin
        in_ch.data <= pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 17);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver readiness: random stall bursts, plus one long hold-off that lets
  // the block fill up and back-pressure its input while items keep coming.
  int stall_left;
  bit long_hold_done;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (!long_hold_done && accepted_items >= 200 && pending_reqs.size() > 8) begin
        long_hold_done = 1'b1;
        stall_left = LongHold;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: updates the predictor on each input or configuration transfer
  // and checks each result transfer against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    req_t r;
    vec_t want;
    vec_t got;
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.data.index == CfgKeyCount) track_len = cfg.data.value;
        else if (cfg.data.index == CfgEmptyOne) unit_default = cfg.data.value[0];
      end
      if (in_ch.valid && in_ch.ready) begin
        r = in_ch.data;
        accepted_items++;
        if (r.cmd == CmdLoad) begin
          time_tab[r.key_slot] = r.key_time;
          x_tab[r.key_slot] = r.key_x;
          y_tab[r.key_slot] = r.key_y;
          z_tab[r.key_slot] = r.key_z;
        end else begin
          expected_vecs.push_back(evaluate_track(r.query_time));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_vecs.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(got.status), 32'd0);
        end else begin
          want = expected_vecs.pop_front();
          if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
          if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
          if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Signed Q16.16 value biased toward the extremes and small magnitudes.
  function automatic bit [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_load(int slot, bit [31:0] t, bit [31:0] x, bit [31:0] y, bit [31:0] z);
    req_t r;
    r = '0;
    r.cmd = CmdLoad;
    r.key_slot = SlotW'(slot);
    r.key_time = t;
    r.key_x = x;
    r.key_y = y;
    r.key_z = z;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  task automatic queue_query(bit [31:0] qt);
    req_t r;
    r = '0;
    r.cmd = CmdQuery;
    r.query_time = qt;
    // The key fields carry noise on a query; the block must ignore them.
    r.key_slot = SlotW'($urandom);
    r.key_time = $urandom;
    r.key_x = $urandom;
    r.key_y = $urandom;
    r.key_z = $urandom;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  // Waits until every item is sent and every result has come back, then lets
  // the block finish any load still in flight.
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_vecs.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] value);
    cfg.data <= '{idx, value};
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Query time: near or between keys of the current track, or anywhere.
  function automatic bit [31:0] pick_query_time(int n);
    int k;
    k = $urandom_range(0, (n > 0) ? n - 1 : 0);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return time_tab[k] + 32'($urandom_range(0, 6)) - 32'd3;
      4, 5, 6: return time_tab[k] + (($urandom % 32'h0010_0000));
      default: return $urandom;
    endcase
  endfunction

  // Loads keys 0..n-1. Shape 0: increasing times; 1: some repeated times;
  // 2: times in no order at all.
  task automatic load_track(int n, int shape);
    bit [31:0] t;
    bit [31:0] step;
    t = $urandom_range(0, 32'h8000_0000);
    step = (n > 0) ? (32'hFFFF_FFFF - t) / n : 1;
    if (step == 0) step = 1;
    for (int s = 0; s < n; s++) begin
      if (shape == 2) t = $urandom;
      else if (!(shape == 1 && $urandom_range(0, 2) == 0)) t = t + 32'($urandom_range(1, step));
      queue_load(s, t, pick_value(), pick_value(), pick_value());
    end
  endtask

  // One phase: load the track, set both registers while idle, then query.
  task automatic run_phase(int count, bit unit_one, int shape, int queries);
    int n;
    n = (count > MaxKeys) ? MaxKeys : count;
    load_track(n, shape);
    drain();
    write_reg(CfgKeyCount, CountW'(count));
    write_reg(CfgEmptyOne, CountW'(unit_one));
    for (int q = 0; q < queries; q++) begin
      // Occasional reload of a random slot in the middle of the queries.
      if ($urandom_range(0, 15) == 0)
        queue_load($urandom_range(0, MaxKeys - 1), $urandom, pick_value(), pick_value(),
                   pick_value());
      queue_query(pick_query_time(n));
    end
  endtask

  initial begin
    int count;
    mismatches = 0;
    accepted_items = 0;
    items_queued = 0;
    calm = 1'b0;
    track_len = '0;
    unit_default = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Write every table entry once so that no query can read an unset key.
    load_track(MaxKeys, 0);
    drain();

    // Directed part: empty track under both defaults, a single key, and a
    // short track with a repeated key time, a backward interval and values
    // at both ends of the range.
    queue_query(32'h0);
    queue_query(32'hFFFF_FFFF);
    drain();
    write_reg(CfgEmptyOne, CountW'(1));
    queue_query(32'h1234_5678);
    drain();
    write_reg(CfgKeyCount, 7'd1);
    queue_query(32'h0);
    queue_load(0, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    queue_load(1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_load(2, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0002_0000);
    queue_load(3, 32'h0000_8000, 32'h0, 32'hFFFF_0000, 32'h0003_0000);
    queue_load(4, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    drain();
    write_reg(CfgKeyCount, 7'd5);
    write_reg(CfgEmptyOne, CountW'(0));
    queue_query(32'h0000_0000);
    queue_query(32'h0000_8000);
    queue_query(32'h0001_0000);
    queue_query(32'h0000_C000);
    queue_query(32'h8000_0000);
    queue_query(32'hFFFF_FFFF);
    drain();
    write_reg(CfgKeyCount, 7'd127);
    queue_query(32'hFFFF_FFFF);
    queue_query(32'h0);

    // Random phases, mostly short well-formed tracks.
    while (items_queued < TargetItems) begin
      case ($urandom_range(0, 19))
        0: count = 0;
        1: count = 1;
        2: count = MaxKeys;
        3: count = 127;
        4: count = $urandom_range(65, 126);
        default: count = $urandom_range(2, 8);
      endcase
      if (items_queued > TargetItems - 150) calm = 1'b1;
      run_phase(count, $urandom_range(0, 1),
                ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2),
                $urandom_range(20, 40));
    end

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/kfl_pkg.sv
rtl/kfl_if.sv
rtl/kfl_ram.sv
rtl/kfl_datapath.sv
rtl/kfl_ctrl.sv
rtl/keyframe_vec3_lerp_unit.sv
rtl/kfl_checker.sv
dv/tb.sv
